/* hw/rtl/pfc_pkg.sv */
// Package for the pixel format converter: pixel and stage types,
// format codes, register indexes and the shared swizzle order table.
// No dependencies.
package pfc_pkg;

   localparam int unsigned COLOR_WIDTH = 8;
   localparam int unsigned SUM_WIDTH   = 10;
   localparam int unsigned FMT_WIDTH   = 4;
   localparam int unsigned BIT_WIDTH   = 3;
   localparam int unsigned CNT_WIDTH   = 4;
   localparam int unsigned WORD_WIDTH  = 32;
   localparam int unsigned PIX_WIDTH   = 64;
   localparam int unsigned CSR_WIDTH   = 32;
   localparam int unsigned ADDR_WIDTH  = 3;

   typedef logic [COLOR_WIDTH-1:0] color_type;
   typedef logic [FMT_WIDTH-1:0]   fmt_type;
   typedef logic [BIT_WIDTH-1:0]   bitpos_type;
   typedef logic [SUM_WIDTH-1:0]   sum_type;
   typedef logic [CNT_WIDTH-1:0]   count_type;
   typedef logic [1:0]             color_sel_type;

   typedef struct packed {
      color_type red;
      color_type grn;
      color_type blu;
      color_type alp;
   } rgba_type;

   typedef struct packed {
      logic       valid;
      logic       error;
      fmt_type    dest_fmt;
      bitpos_type dest_bit;
   } ctl_type;

   typedef color_sel_type [2:0] swz_type;

   // color selects
   localparam color_sel_type SEL_RED = 2'd0;
   localparam color_sel_type SEL_GRN = 2'd1;
   localparam color_sel_type SEL_BLU = 2'd2;

   // register indexes
   localparam logic REG_SOURCE_FORMAT = 1'b0;
   localparam logic REG_DEST_FORMAT   = 1'b1;

   // swizzle codes, shared by source and destination
   localparam fmt_type FMT_RGBA = 4'd0;
   localparam fmt_type FMT_RBGA = 4'd1;
   localparam fmt_type FMT_BRGA = 4'd2;
   localparam fmt_type FMT_BGRA = 4'd3;
   localparam fmt_type FMT_GBRA = 4'd4;
   localparam fmt_type FMT_GRBA = 4'd5;

   // source formats
   localparam fmt_type SRC_LAST_SWZ = 4'd5;
   localparam fmt_type SRC_BIT_MONO = 4'd15;

   // destination formats
   localparam fmt_type DST_LAST_SWZ = 4'd5;
   localparam fmt_type DST_RGBI     = 4'd6;
   localparam fmt_type DST_R3G3B2   = 4'd7;
   localparam fmt_type DST_VGA_ATTR = 4'd8;
   localparam fmt_type DST_MONO8    = 4'd9;
   localparam fmt_type DST_MONO16   = 4'd10;
   localparam fmt_type DST_MONO32   = 4'd11;
   localparam fmt_type DST_MONO64   = 4'd12;
   localparam fmt_type DST_VGA_CHAR = 4'd13;
   localparam fmt_type DST_ASCII    = 4'd14;
   localparam fmt_type DST_BIT_MONO = 4'd15;

   // thresholds and characters
   localparam color_type LEVEL_HALF  = 8'h80;
   localparam color_type LEVEL_LOW   = 8'h60;
   localparam color_type LEVEL_HIGH  = 8'hC0;
   localparam color_type CHAR_HASH   = 8'h23;
   localparam color_type CHAR_SPACE  = 8'h20;
   localparam color_type COLOR_FULL  = 8'hFF;
   localparam color_type MASK_ALL    = 8'hFF;

   // mean = sum / 3 as (sum * 683) >> 11, exact for sums up to 765
   localparam sum_type     MEAN_RECIP = 10'd683;
   localparam int unsigned MEAN_SHIFT = 11;
   localparam int unsigned PROD_WIDTH = 2 * SUM_WIDTH;

   localparam count_type COUNT_ONE   = 4'd1;
   localparam count_type COUNT_TWO   = 4'd2;
   localparam count_type COUNT_FOUR  = 4'd4;
   localparam count_type COUNT_EIGHT = 4'd8;

   // color carried by bytes 0..2 for swizzle codes 0..5
   function automatic swz_type swz_order(input fmt_type code);
      swz_type order;
      case (code)
         FMT_RGBA: order = '{SEL_BLU, SEL_GRN, SEL_RED};
         FMT_RBGA: order = '{SEL_GRN, SEL_BLU, SEL_RED};
         FMT_BRGA: order = '{SEL_GRN, SEL_RED, SEL_BLU};
         FMT_BGRA: order = '{SEL_RED, SEL_GRN, SEL_BLU};
         FMT_GBRA: order = '{SEL_RED, SEL_BLU, SEL_GRN};
         default:  order = '{SEL_BLU, SEL_RED, SEL_GRN};
      endcase
      return order;
   endfunction

endpackage

/* hw/rtl/pfc_unpack.sv */
// First stage: unpack the source word into RGBA and form the color sum.
// Depends on pfc_pkg.
module pfc_unpack (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  pfc_pkg::fmt_type    source_format,
   input  pfc_pkg::fmt_type    dest_format,
   input  logic [31:0]         source_word,
   input  pfc_pkg::bitpos_type source_bit,
   input  pfc_pkg::bitpos_type dest_bit,
   output pfc_pkg::ctl_type    ctl_out,
   output pfc_pkg::rgba_type   color_set_out,
   output pfc_pkg::sum_type    sum_out
);

   pfc_pkg::ctl_type   ctl_ff, ctl_in;
   pfc_pkg::rgba_type  rgba_ff, rgba_in;
   pfc_pkg::sum_type   sum_ff, sum_in;
   pfc_pkg::swz_type   order;
   pfc_pkg::color_type bytes [3];
   pfc_pkg::color_type colors [3];
   pfc_pkg::color_type mono;

   always_comb begin
      order     = pfc_pkg::swz_order(source_format);
      bytes[0]  = source_word[7:0];
      bytes[1]  = source_word[15:8];
      bytes[2]  = source_word[23:16];
      colors[0] = '0;
      colors[1] = '0;
      colors[2] = '0;
      for (int k = 0; k < 3; k++) begin
         colors[order[k]] = bytes[k];
      end
      mono = bytes[0][source_bit] ? pfc_pkg::COLOR_FULL : '0;

      ctl_in.valid    = in_valid;
      ctl_in.dest_fmt = dest_format;
      ctl_in.dest_bit = dest_bit;
      if (source_format <= pfc_pkg::SRC_LAST_SWZ) begin
         ctl_in.error = 1'b0;
         rgba_in      = '{red: colors[pfc_pkg::SEL_RED], grn: colors[pfc_pkg::SEL_GRN],
                          blu: colors[pfc_pkg::SEL_BLU], alp: source_word[31:24]};
      end else if (source_format == pfc_pkg::SRC_BIT_MONO) begin
         ctl_in.error = 1'b0;
         rgba_in      = '{red: mono, grn: mono, blu: mono, alp: mono};
      end else begin
         ctl_in.error = 1'b1;
         rgba_in      = '0;
      end
      sum_in = pfc_pkg::sum_type'(rgba_in.red) + pfc_pkg::sum_type'(rgba_in.grn)
             + pfc_pkg::sum_type'(rgba_in.blu);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.error    <= ctl_in.error;
      ctl_ff.dest_fmt <= ctl_in.dest_fmt;
      ctl_ff.dest_bit <= ctl_in.dest_bit;
      rgba_ff         <= rgba_in;
      sum_ff          <= sum_in;
   end

   assign ctl_out       = ctl_ff;
   assign color_set_out = rgba_ff;
   assign sum_out       = sum_ff;

endmodule

/* hw/rtl/pfc_mean.sv */
// Second stage: divide the color sum by three through a reciprocal multiply.
// Depends on pfc_pkg.
module pfc_mean (
   input  logic               clock,
   input  logic               reset,
   input  pfc_pkg::ctl_type   ctl_in_s,
   input  pfc_pkg::rgba_type  rgba_in_s,
   input  pfc_pkg::sum_type   sum_in_s,
   output pfc_pkg::ctl_type   ctl_out,
   output pfc_pkg::rgba_type  color_set_out,
   output pfc_pkg::color_type mean_out
);

   pfc_pkg::ctl_type                    ctl_ff;
   pfc_pkg::rgba_type                   rgba_ff;
   pfc_pkg::color_type                  mean_ff, mean_in;
   logic [pfc_pkg::PROD_WIDTH-1:0]      prod;

   always_comb begin
      prod    = sum_in_s * pfc_pkg::MEAN_RECIP;
      mean_in = prod[pfc_pkg::MEAN_SHIFT +: pfc_pkg::COLOR_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in_s.valid;
      end
      ctl_ff.error    <= ctl_in_s.error;
      ctl_ff.dest_fmt <= ctl_in_s.dest_fmt;
      ctl_ff.dest_bit <= ctl_in_s.dest_bit;
      rgba_ff         <= rgba_in_s;
      mean_ff         <= mean_in;
   end

   assign ctl_out       = ctl_ff;
   assign color_set_out = rgba_ff;
   assign mean_out      = mean_ff;

endmodule

/* hw/rtl/pfc_pack.sv */
// Third stage: pack RGBA and mean into the destination format, register results.
// Depends on pfc_pkg.
module pfc_pack (
   input  logic               clock,
   input  logic               reset,
   input  pfc_pkg::ctl_type   ctl_in_s,
   input  pfc_pkg::rgba_type  rgba_in_s,
   input  pfc_pkg::color_type mean_in_s,
   output logic               rsp_valid,
   output logic [63:0]        rsp_pixel_out,
   output logic [3:0]         rsp_byte_count,
   output logic [7:0]         rsp_bit_mask,
   output logic               rsp_format_error
);

   logic                 valid_ff;
   logic [63:0]          pixel_ff, pixel_in;
   pfc_pkg::count_type   count_ff, count_in;
   pfc_pkg::color_type   mask_ff, mask_in;
   logic                 error_ff;
   pfc_pkg::swz_type     order;
   pfc_pkg::color_type   colors [3];
   pfc_pkg::color_type   mean;
   pfc_pkg::color_type   bit_sel;
   logic                 bright;

   always_comb begin
      mean      = mean_in_s;
      order     = pfc_pkg::swz_order(ctl_in_s.dest_fmt);
      colors[0] = rgba_in_s.red;
      colors[1] = rgba_in_s.grn;
      colors[2] = rgba_in_s.blu;
      bit_sel   = pfc_pkg::color_type'(1) << ctl_in_s.dest_bit;
      bright    = mean > pfc_pkg::LEVEL_HALF;
      pixel_in  = '0;
      count_in  = pfc_pkg::COUNT_ONE;
      mask_in   = pfc_pkg::MASK_ALL;

      if (ctl_in_s.dest_fmt <= pfc_pkg::DST_LAST_SWZ) begin
         pixel_in = {32'd0, rgba_in_s.alp, colors[order[2]], colors[order[1]],
                     colors[order[0]]};
         count_in = pfc_pkg::COUNT_FOUR;
      end else begin
         case (ctl_in_s.dest_fmt)
            pfc_pkg::DST_RGBI: begin
               pixel_in[0] = rgba_in_s.red >= pfc_pkg::LEVEL_HALF;
               pixel_in[1] = rgba_in_s.grn >= pfc_pkg::LEVEL_HALF;
               pixel_in[2] = rgba_in_s.blu >= pfc_pkg::LEVEL_HALF;
               pixel_in[3] = mean >= pfc_pkg::LEVEL_LOW
                          || rgba_in_s.red > pfc_pkg::LEVEL_HIGH
                          || rgba_in_s.grn > pfc_pkg::LEVEL_HIGH
                          || rgba_in_s.blu > pfc_pkg::LEVEL_HIGH;
            end
            pfc_pkg::DST_R3G3B2: begin
               pixel_in[7:0] = {rgba_in_s.blu[7:6], rgba_in_s.grn[7:5], rgba_in_s.red[7:5]};
            end
            pfc_pkg::DST_VGA_ATTR: begin
               pixel_in[4] = rgba_in_s.red >= pfc_pkg::LEVEL_LOW;
               pixel_in[5] = rgba_in_s.grn >= pfc_pkg::LEVEL_LOW;
               pixel_in[6] = rgba_in_s.blu >= pfc_pkg::LEVEL_LOW;
               pixel_in[7] = mean >= pfc_pkg::LEVEL_HALF;
            end
            pfc_pkg::DST_MONO8: begin
               pixel_in[7:0] = mean;
            end
            pfc_pkg::DST_MONO16: begin
               pixel_in[15:8] = mean;
               count_in       = pfc_pkg::COUNT_TWO;
            end
            pfc_pkg::DST_MONO32: begin
               pixel_in[31:24] = mean;
               count_in        = pfc_pkg::COUNT_FOUR;
            end
            pfc_pkg::DST_MONO64: begin
               pixel_in[63:56] = mean;
               count_in        = pfc_pkg::COUNT_EIGHT;
            end
            pfc_pkg::DST_VGA_CHAR, pfc_pkg::DST_ASCII: begin
               pixel_in[7:0] = bright ? pfc_pkg::CHAR_HASH : pfc_pkg::CHAR_SPACE;
            end
            default: begin
               mask_in       = bit_sel;
               pixel_in[7:0] = bright ? bit_sel : '0;
            end
         endcase
      end

      // drop everything on an unsupported source
      if (ctl_in_s.error) begin
         pixel_in = '0;
         count_in = '0;
         mask_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_in_s.valid;
      end
      pixel_ff <= pixel_in;
      count_ff <= count_in;
      mask_ff  <= mask_in;
      error_ff <= ctl_in_s.error;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pixel_out    = pixel_ff;
   assign rsp_byte_count   = count_ff;
   assign rsp_bit_mask     = mask_ff;
   assign rsp_format_error = error_ff;

endmodule

/* hw/rtl/pixel_format_converter.sv */
// Pixel format converter: three-stage pipeline (unpack, divide by three, pack).
// Each request passes the unpack, mean and pack registers before the result
// strobe goes high; one request per cycle sustained, busy never rises.
// Synchronous reset clears the format registers to 0 and empties the pipeline.
// Depends on pfc_pkg, pfc_unpack, pfc_mean, pfc_pack.
module pixel_format_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_source_word,
   input  logic [2:0]  req_source_bit,
   input  logic [2:0]  req_dest_bit,
   output logic        rsp_valid,
   output logic [63:0] rsp_pixel_out,
   output logic [3:0]  rsp_byte_count,
   output logic [7:0]  rsp_bit_mask,
   output logic        rsp_format_error,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   pfc_pkg::fmt_type   src_fmt_ff, src_fmt_in;
   pfc_pkg::fmt_type   dst_fmt_ff, dst_fmt_in;
   logic               csr_write;
   logic               csr_sel;
   logic               req_accept;

   pfc_pkg::ctl_type   s1_ctl, s2_ctl;
   pfc_pkg::rgba_type  s1_rgba, s2_rgba;
   pfc_pkg::sum_type   s1_sum;
   pfc_pkg::color_type s2_mean;

   assign busy       = 1'b0;
   assign pready     = 1'b1;
   assign req_accept = start && !busy;
   assign csr_write  = psel && penable && pwrite && pready;
   assign csr_sel    = paddr[2];

   always_comb begin
      src_fmt_in = src_fmt_ff;
      dst_fmt_in = dst_fmt_ff;
      if (csr_write) begin
         case (csr_sel)
            pfc_pkg::REG_SOURCE_FORMAT: src_fmt_in = pwdata[pfc_pkg::FMT_WIDTH-1:0];
            pfc_pkg::REG_DEST_FORMAT:   dst_fmt_in = pwdata[pfc_pkg::FMT_WIDTH-1:0];
            default: begin
               src_fmt_in = src_fmt_ff;
            end
         endcase
      end
      case (csr_sel)
         pfc_pkg::REG_SOURCE_FORMAT: prdata = {28'd0, src_fmt_ff};
         pfc_pkg::REG_DEST_FORMAT:   prdata = {28'd0, dst_fmt_ff};
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_fmt_ff <= '0;
         dst_fmt_ff <= '0;
      end else begin
         src_fmt_ff <= src_fmt_in;
         dst_fmt_ff <= dst_fmt_in;
      end
   end

   pfc_unpack u_unpack (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_accept),
      .source_format (src_fmt_ff),
      .dest_format   (dst_fmt_ff),
      .source_word   (req_source_word),
      .source_bit    (req_source_bit),
      .dest_bit      (req_dest_bit),
      .ctl_out       (s1_ctl),
      .color_set_out (s1_rgba),
      .sum_out       (s1_sum)
   );

   pfc_mean u_mean (
      .clock         (clock),
      .reset         (reset),
      .ctl_in_s      (s1_ctl),
      .rgba_in_s     (s1_rgba),
      .sum_in_s      (s1_sum),
      .ctl_out       (s2_ctl),
      .color_set_out (s2_rgba),
      .mean_out      (s2_mean)
   );

   pfc_pack u_pack (
      .clock            (clock),
      .reset            (reset),
      .ctl_in_s         (s2_ctl),
      .rgba_in_s        (s2_rgba),
      .mean_in_s        (s2_mean),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_bit_mask     (rsp_bit_mask),
      .rsp_format_error (rsp_format_error)
   );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for pixel_format_converter: command-style requests
// with random idle bursts, APB format writes and a scoreboard that predicts
// each converted pixel. Depends on pfc_pkg and the converter RTL.
module tb_top;
   import pfc_pkg::*;

   localparam int unsigned PIPE_LATENCY  = 3;
   localparam int unsigned SETTLE_CYCLES = PIPE_LATENCY + 2;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned MAX_REPORTS   = 10;
   localparam int unsigned PHASE_COUNT   = 48;
   localparam int unsigned PHASE_PIXELS  = 20;
   localparam int unsigned QUIET_PHASES  = 8;

   localparam fmt_type SRC_FIRST_BAD = 4'd6;
   localparam fmt_type SRC_LAST_BAD  = 4'd14;

   typedef struct packed {
      logic [PIX_WIDTH-1:0] pixel;
      count_type            count;
      color_type            mask;
      logic                 error;
   } pixel_out_type;

   class pixel_ledger;
      fmt_type       src_fmt;
      fmt_type       dst_fmt;
      pixel_out_type expected_pixels[$];
      int unsigned   mismatches;
      int unsigned   pixels_sent;
      int unsigned   pixels_checked;
      int unsigned   errors_flagged;

      function new();
         src_fmt = FMT_RGBA;
         dst_fmt = FMT_RGBA;
         mismatches = 0;
         pixels_sent = 0;
         pixels_checked = 0;
         errors_flagged = 0;
      endfunction

      function void set_format(logic idx, fmt_type value);
         if (idx == REG_SOURCE_FORMAT) begin
            src_fmt = value;
         end else begin
            dst_fmt = value;
         end
      endfunction

      // color carried by byte k of a swizzled word
      function color_sel_type color_at(fmt_type code, int unsigned k);
         color_sel_type ord[3];
         case (code)
            FMT_RGBA: ord = '{SEL_RED, SEL_GRN, SEL_BLU};
            FMT_RBGA: ord = '{SEL_RED, SEL_BLU, SEL_GRN};
            FMT_BRGA: ord = '{SEL_BLU, SEL_RED, SEL_GRN};
            FMT_BGRA: ord = '{SEL_BLU, SEL_GRN, SEL_RED};
            FMT_GBRA: ord = '{SEL_GRN, SEL_BLU, SEL_RED};
            default:  ord = '{SEL_GRN, SEL_RED, SEL_BLU};
         endcase
         return ord[k];
      endfunction

      function pixel_out_type predict_pixel(logic [WORD_WIDTH-1:0] word, bitpos_type sbit,
                                            bitpos_type dbit);
         color_type     bytes[4];
         color_type     color[3];
         color_type     alp;
         color_type     mono;
         color_type     rd, gr, bl, mean;
         sum_type       total;
         pixel_out_type r;
         for (int k = 0; k < 4; k++) bytes[k] = word[8*k +: 8];
         r.pixel = '0;
         r.count = COUNT_ONE;
         r.mask  = MASK_ALL;
         r.error = 1'b0;
         alp = bytes[3];
         if (src_fmt <= SRC_LAST_SWZ) begin
            for (int k = 0; k < 3; k++) color[color_at(src_fmt, k)] = bytes[k];
         end else if (src_fmt == SRC_BIT_MONO) begin
            mono = bytes[0][sbit] ? COLOR_FULL : '0;
            for (int k = 0; k < 3; k++) color[k] = mono;
            alp = mono;
         end else begin
            r.count = '0;
            r.mask  = '0;
            r.error = 1'b1;
            return r;
         end
         rd = color[SEL_RED];
         gr = color[SEL_GRN];
         bl = color[SEL_BLU];
         total = sum_type'(rd) + sum_type'(gr) + sum_type'(bl);
         mean = color_type'(total / 3);
         if (dst_fmt <= DST_LAST_SWZ) begin
            for (int k = 0; k < 3; k++) r.pixel[8*k +: 8] = color[color_at(dst_fmt, k)];
            r.pixel[31:24] = alp;
            r.count = COUNT_FOUR;
         end else begin
            case (dst_fmt)
               DST_RGBI: r.pixel[3:0] = {
                  (mean >= LEVEL_LOW) || (rd > LEVEL_HIGH) || (gr > LEVEL_HIGH)
                     || (bl > LEVEL_HIGH),
                  bl >= LEVEL_HALF, gr >= LEVEL_HALF, rd >= LEVEL_HALF};
               DST_R3G3B2: r.pixel[7:0] = {color[SEL_BLU][7:6], color[SEL_GRN][7:5],
                                           color[SEL_RED][7:5]};
               DST_VGA_ATTR: r.pixel[7:4] = {mean >= LEVEL_HALF, bl >= LEVEL_LOW,
                                             gr >= LEVEL_LOW, rd >= LEVEL_LOW};
               DST_MONO8: r.pixel[7:0] = mean;
               DST_MONO16: begin
                  r.pixel[15:8] = mean;
                  r.count = COUNT_TWO;
               end
               DST_MONO32: begin
                  r.pixel[31:24] = mean;
                  r.count = COUNT_FOUR;
               end
               DST_MONO64: begin
                  r.pixel[63:56] = mean;
                  r.count = COUNT_EIGHT;
               end
               DST_VGA_CHAR, DST_ASCII:
                  r.pixel[7:0] = (mean > LEVEL_HALF) ? CHAR_HASH : CHAR_SPACE;
               default: begin
                  r.mask = color_type'(1) << dbit;
                  r.pixel[7:0] = (mean > LEVEL_HALF) ? r.mask : '0;
               end
            endcase
         end
         return r;
      endfunction

      function void note_request(logic [WORD_WIDTH-1:0] word, bitpos_type sbit,
                                 bitpos_type dbit);
         expected_pixels.push_back(predict_pixel(word, sbit, dbit));
         pixels_sent++;
      endfunction

      function void check_result(pixel_out_type got);
         pixel_out_type want;
         pixels_checked++;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected pixel: pix=%h cnt=%0d mask=%h err=%b",
                        got.pixel, got.count, got.mask, got.error);
            return;
         end
         want = expected_pixels.pop_front();
         if (want.error) errors_flagged++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("mismatch src %0d dst %0d: expected pix=%h cnt=%0d mask=%h err=%b",
                        src_fmt, dst_fmt, want.pixel, want.count, want.mask, want.error);
               $display("   got pix=%h cnt=%0d mask=%h err=%b",
                        got.pixel, got.count, got.mask, got.error);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [WORD_WIDTH-1:0]  req_source_word;
   bitpos_type             req_source_bit;
   bitpos_type             req_dest_bit;
   logic                   rsp_valid;
   logic [PIX_WIDTH-1:0]   rsp_pixel_out;
   count_type              rsp_byte_count;
   color_type              rsp_bit_mask;
   logic                   rsp_format_error;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [ADDR_WIDTH-1:0]  paddr;
   logic [CSR_WIDTH-1:0]   pwdata;
   logic [CSR_WIDTH-1:0]   prdata;
   logic                   pready;

   pixel_ledger ledger;
   int unsigned stall_cycles = 0;
   int unsigned settings_used = 0;

   pixel_format_converter i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_source_word  (req_source_word),
      .req_source_bit   (req_source_bit),
      .req_dest_bit     (req_dest_bit),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_bit_mask     (rsp_bit_mask),
      .rsp_format_error (rsp_format_error),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            ledger.note_request(req_source_word, req_source_bit, req_dest_bit);
         if (rsp_valid)
            ledger.check_result('{rsp_pixel_out, rsp_byte_count, rsp_bit_mask,
                                  rsp_format_error});
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no request or result for %0d cycles", STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [WORD_WIDTH-1:0] random_word();
      logic [WORD_WIDTH-1:0] word;
      for (int k = 0; k < 4; k++) begin
         case ($urandom_range(0, 7))
            0:       word[8*k +: 8] = '0;
            1:       word[8*k +: 8] = COLOR_FULL;
            2:       word[8*k +: 8] = color_type'(LEVEL_HALF - 1 + $urandom_range(0, 2));
            3:       word[8*k +: 8] = color_type'(LEVEL_LOW - 1 + $urandom_range(0, 2));
            4:       word[8*k +: 8] = color_type'(LEVEL_HIGH - 1 + $urandom_range(0, 2));
            default: word[8*k +: 8] = color_type'($urandom_range(0, 255));
         endcase
      end
      return word;
   endfunction

   task automatic send_pixel(input logic [WORD_WIDTH-1:0] word, input bitpos_type sbit,
                             input bitpos_type dbit);
      @(negedge clock);
      req_source_word = word;
      req_source_bit  = sbit;
      req_dest_bit    = dbit;
      start = 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(input int unsigned cycles);
      @(negedge clock);
      start = 1'b0;
      req_source_word = $urandom;
      req_source_bit  = bitpos_type'($urandom_range(0, 7));
      req_dest_bit    = bitpos_type'($urandom_range(0, 7));
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic write_format(input logic idx, input fmt_type value);
      logic [CSR_WIDTH-1:0] data;
      data = $urandom;
      data[FMT_WIDTH-1:0] = value;
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      ledger.set_format(idx, value);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic set_formats(input fmt_type src, input fmt_type dst);
      @(negedge clock);
      start = 1'b0;
      while (ledger.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_format(REG_SOURCE_FORMAT, src);
      write_format(REG_DEST_FORMAT, dst);
      settings_used++;
   endtask

   initial begin
      fmt_type     src;
      fmt_type     dst;
      int unsigned pick;
      bit          idling;

      ledger = new();
      reset = 1'b1;
      start = 1'b0;
      req_source_word = '0;
      req_source_bit  = '0;
      req_dest_bit    = '0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_formats(FMT_RGBA, FMT_RGBA);
      send_pixel(32'h0000_0000, 3'd0, 3'd0);
      send_pixel(32'hFFFF_FFFF, 3'd7, 3'd7);
      send_pixel(32'h1234_5678, 3'd0, 3'd7);
      set_formats(SRC_BIT_MONO, DST_BIT_MONO);
      send_pixel(32'hFFFF_FF01, 3'd0, 3'd7);
      send_pixel(32'h0000_007F, 3'd7, 3'd0);
      send_pixel(32'h0000_0080, 3'd7, 3'd3);
      set_formats(SRC_FIRST_BAD, DST_RGBI);
      send_pixel(32'hFFFF_FFFF, 3'd7, 3'd7);
      set_formats(SRC_LAST_BAD, DST_MONO64);
      send_pixel(32'h1234_5678, 3'd0, 3'd0);
      set_formats(FMT_BGRA, DST_MONO64);
      send_pixel(32'hFFFF_FFFF, 3'd0, 3'd0);
      send_pixel(32'h0000_0000, 3'd7, 3'd7);
      set_formats(FMT_GRBA, DST_ASCII);
      send_pixel(32'h0080_8080, 3'd0, 3'd0);
      send_pixel(32'h0081_8181, 3'd0, 3'd0);
      set_formats(FMT_RBGA, DST_RGBI);
      send_pixel(32'h0060_6060, 3'd0, 3'd0);
      send_pixel(32'h0000_00C1, 3'd0, 3'd0);
      send_pixel(32'h005F_5F5F, 3'd0, 3'd0);
      set_formats(FMT_BRGA, DST_VGA_ATTR);
      send_pixel(32'h8060_6060, 3'd0, 3'd0);
      send_pixel(32'h7F5F_5F5F, 3'd0, 3'd0);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         dst = fmt_type'(phase % 16);
         if (phase < 16) begin
            pick = phase % 7;
         end else begin
            pick = $urandom_range(0, 6);
         end
         src = (pick == 6) ? SRC_BIT_MONO : fmt_type'(pick);
         if (phase >= 16 && $urandom_range(0, 7) == 0)
            src = fmt_type'($urandom_range(SRC_FIRST_BAD, SRC_LAST_BAD));
         set_formats(src, dst);
         idling = (phase < PHASE_COUNT - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
         repeat (PHASE_PIXELS) begin
            if (idling && $urandom_range(0, 5) == 0) pause($urandom_range(1, 12));
            send_pixel(random_word(), bitpos_type'($urandom_range(0, 7)),
                       bitpos_type'($urandom_range(0, 7)));
         end
      end

      @(negedge clock);
      start = 1'b0;
      while (ledger.pending() != 0) @(negedge clock);
      repeat (2 * SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d pixels under %0d format settings, %0d with a bad source.",
               ledger.pixels_sent, settings_used, ledger.errors_flagged);
      $display("Checked %0d results, %0d mismatches.", ledger.pixels_checked,
               ledger.mismatches);
      if (ledger.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
